/* hdl/ugid_pkg.sv */
// ugid_pkg: shared constants, result kind codes, kana atlas table and
// the structs passed between the decoder sub-blocks
// no dependencies
package ugid_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned ATLAS_W  = 7;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned LEFT_W   = 2;

  localparam logic [COUNT_W-1:0] SLOT_COUNT    = 9'd256;
  localparam logic [COUNT_W-1:0] LIMIT_DEFAULT = 9'd256;

  localparam logic [KIND_W-1:0] KIND_HIRAGANA   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_KATAKANA   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_ALNUM      = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NEWLINE    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_HALF_SPACE = 4'd4;
  localparam logic [KIND_W-1:0] KIND_FULL_SPACE = 4'd5;
  localparam logic [KIND_W-1:0] KIND_SKIPPED    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_BEYOND     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_NONE       = 4'd8;

  localparam logic [CP_W-1:0] CP_NEWLINE    = 21'h0A;
  localparam logic [CP_W-1:0] CP_SPACE      = 21'h20;
  localparam logic [CP_W-1:0] CP_FULL_SPACE = 21'h3000;
  localparam logic [CP_W-1:0] CP_HIRA_LO    = 21'h3040;
  localparam logic [CP_W-1:0] CP_HIRA_HI    = 21'h309F;
  localparam logic [CP_W-1:0] CP_KATA_LO    = 21'h30A0;
  localparam logic [CP_W-1:0] CP_KATA_HI    = 21'h30FF;
  localparam logic [CP_W-1:0] CP_LONG_MARK  = 21'h30FC;

  localparam logic [7:0] NO_ENTRY   = 8'hFF;
  localparam logic [7:0] LONG_MARK_INDEX = 8'd80;
  localparam int unsigned KANA_DEPTH = 96;

  localparam logic [7:0] KANA_TABLE [KANA_DEPTH] = '{
    8'hFF, 8'd71, 8'd0,  8'd72, 8'd1,  8'd73, 8'd2,  8'd74,
    8'd3,  8'd75, 8'd4,  8'd5,  8'd46, 8'd6,  8'd47, 8'd7,
    8'd48, 8'd8,  8'd49, 8'd9,  8'd50, 8'd10, 8'd51, 8'd11,
    8'd52, 8'd12, 8'd53, 8'd13, 8'd54, 8'd14, 8'd55, 8'd15,
    8'd56, 8'd16, 8'd57, 8'd79, 8'd17, 8'd58, 8'd18, 8'd59,
    8'd19, 8'd60, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
    8'd61, 8'd66, 8'd26, 8'd62, 8'd67, 8'd27, 8'd63, 8'd68,
    8'd28, 8'd64, 8'd69, 8'd29, 8'd65, 8'd70, 8'd30, 8'd31,
    8'd32, 8'd33, 8'd34, 8'd76, 8'd35, 8'd77, 8'd36, 8'd78,
    8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'hFF, 8'd43,
    8'hFF, 8'hFF, 8'd44, 8'd45, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  function automatic logic [7:0] kana_lookup(input logic [6:0] ofs);
    logic [7:0] val;
    if (ofs < 7'(KANA_DEPTH)) begin
      val = KANA_TABLE[ofs];
    end else begin
      val = NO_ENTRY;
    end
    return val;
  endfunction

  typedef struct packed {
    logic              done;
    logic [CP_W-1:0]   cp;
    logic [CP_W-1:0]   partial_nxt;
    logic [LEFT_W-1:0] bytes_left_nxt;
  } step_t;

  typedef struct packed {
    logic               draw;
    logic [KIND_W-1:0]  kind;
    logic [ATLAS_W-1:0] atlas;
    logic [SLOT_W-1:0]  slot;
  } class_t;

endpackage

/* hdl/ugid_if.sv */
// ugid_in_if / ugid_out_if: valid-ready channels for text bytes and glyph words
// no dependencies
interface ugid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ugid_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [3:0]  glyph_kind;
  logic [6:0]  atlas_index;
  logic [7:0]  glyph_slot;
  logic        text_end;

  modport source (output valid, output code_point, output glyph_kind, output atlas_index,
                  output glyph_slot, output text_end, input ready);
  modport sink   (input valid, input code_point, input glyph_kind, input atlas_index,
                  input glyph_slot, input text_end, output ready);
endinterface

/* hdl/ugid_utf8_step.sv */
// ugid_utf8_step: one byte of utf-8 sequence assembly
// depends on ugid_pkg
module ugid_utf8_step (
  input  logic [ugid_pkg::BYTE_W-1:0] text_byte,
  input  logic [ugid_pkg::CP_W-1:0]   partial_code,
  input  logic [ugid_pkg::LEFT_W-1:0] bytes_left,
  output ugid_pkg::step_t             step
);
  import ugid_pkg::*;

  logic [LEFT_W-1:0] left_dec;
  logic [CP_W-1:0]   payload;
  logic [CP_W-1:0]   merged;

  assign left_dec = bytes_left - 2'd1;

  always_comb begin
    unique case (left_dec)
      2'd0:    payload = {15'd0, text_byte[5:0]};
      2'd1:    payload = {9'd0, text_byte[5:0], 6'd0};
      2'd2:    payload = {3'd0, text_byte[5:0], 12'd0};
      default: payload = '0;
    endcase
    merged = partial_code | payload;
  end

  always_comb begin
    step.done           = 1'b0;
    step.cp             = '0;
    step.partial_nxt    = partial_code;
    step.bytes_left_nxt = bytes_left;
    if (bytes_left == '0) begin
      if (text_byte[7] == 1'b0) begin
        step.done = 1'b1;
        step.cp   = {13'd0, text_byte};
      end else if (text_byte[7:5] == 3'b110) begin
        step.partial_nxt    = {10'd0, text_byte[4:0], 6'd0};
        step.bytes_left_nxt = 2'd1;
      end else if (text_byte[7:4] == 4'b1110) begin
        step.partial_nxt    = {5'd0, text_byte[3:0], 12'd0};
        step.bytes_left_nxt = 2'd2;
      end else if (text_byte[7:3] == 5'b11110) begin
        step.partial_nxt    = {text_byte[2:0], 18'd0};
        step.bytes_left_nxt = 2'd3;
      end
    end else begin
      step.bytes_left_nxt = left_dec;
      if (left_dec == '0) begin
        step.done        = 1'b1;
        step.cp          = merged;
        step.partial_nxt = '0;
      end else begin
        step.partial_nxt = merged;
      end
    end
  end
endmodule

/* hdl/ugid_classify.sv */
// ugid_classify: sorts a codepoint into its glyph kind, atlas index and slot
// depends on ugid_pkg
module ugid_classify (
  input  logic [ugid_pkg::CP_W-1:0]    code_point,
  input  logic [ugid_pkg::COUNT_W-1:0] glyph_count,
  input  logic [ugid_pkg::COUNT_W-1:0] glyph_limit,
  output ugid_pkg::class_t             cls
);
  import ugid_pkg::*;

  logic [COUNT_W-1:0] lim;
  logic [6:0]         low7;
  logic [7:0]         entry;
  logic [KIND_W-1:0]  cand_kind;
  logic               cand;

  assign lim  = (glyph_limit > SLOT_COUNT) ? SLOT_COUNT : glyph_limit;
  assign low7 = code_point[6:0];

  always_comb begin
    cand      = 1'b0;
    cand_kind = KIND_SKIPPED;
    entry     = NO_ENTRY;
    if (code_point >= CP_HIRA_LO && code_point <= CP_HIRA_HI) begin
      cand      = 1'b1;
      cand_kind = KIND_HIRAGANA;
      entry     = kana_lookup(low7 - 7'h40);
    end else if (code_point >= CP_KATA_LO && code_point <= CP_KATA_HI) begin
      cand      = 1'b1;
      cand_kind = KIND_KATAKANA;
      entry     = (code_point == CP_LONG_MARK) ? LONG_MARK_INDEX
                                               : kana_lookup(low7 - 7'h20);
    end else if (code_point >= 21'h61 && code_point <= 21'h7A) begin
      cand      = 1'b1;
      cand_kind = KIND_ALNUM;
      entry     = {1'b0, low7 - 7'h61};
    end else if (code_point >= 21'h41 && code_point <= 21'h5A) begin
      cand      = 1'b1;
      cand_kind = KIND_ALNUM;
      entry     = {1'b0, low7 - 7'h41 + 7'd26};
    end else if (code_point >= 21'h30 && code_point <= 21'h39) begin
      cand      = 1'b1;
      cand_kind = KIND_ALNUM;
      entry     = {1'b0, low7 - 7'h30 + 7'd52};
    end
  end

  always_comb begin
    cls.draw  = 1'b0;
    cls.kind  = KIND_SKIPPED;
    cls.atlas = '0;
    cls.slot  = '0;
    if (glyph_count >= lim) begin
      cls.kind = KIND_BEYOND;
    end else if (code_point == CP_NEWLINE) begin
      cls.kind = KIND_NEWLINE;
    end else if (code_point == CP_SPACE) begin
      cls.kind = KIND_HALF_SPACE;
    end else if (code_point == CP_FULL_SPACE) begin
      cls.kind = KIND_FULL_SPACE;
    end else if (cand && entry != NO_ENTRY) begin
      cls.draw  = 1'b1;
      cls.kind  = cand_kind;
      cls.atlas = entry[ATLAS_W-1:0];
      cls.slot  = glyph_count[SLOT_W-1:0];
    end
  end
endmodule

/* hdl/utf8_glyph_index_decoder.sv */
// utf8_glyph_index_decoder: utf-8 byte stream to glyph kind, atlas index and slot
// an accepted byte passes the input reg, then the result reg, before its word is valid
// throughput: one byte per cycle; the result register stalls only on out_ch.ready
// bytes that finish no codepoint and are not final produce no word
// reset (rst_n low, synchronous): pipeline empty, decoder state zero, glyph_limit LIMIT_RESET (default 256)
// depends on ugid_pkg, ugid_if, ugid_utf8_step, ugid_classify
module utf8_glyph_index_decoder #(
  parameter logic [ugid_pkg::COUNT_W-1:0] LIMIT_RESET = ugid_pkg::LIMIT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ugid_pkg::COUNT_W-1:0] cfg_wdata,
  ugid_in_if.sink                      in_ch,
  ugid_out_if.source                   out_ch
);
  import ugid_pkg::*;

  logic               a_valid_r;
  logic [BYTE_W-1:0]  a_byte_r;
  logic               a_fin_r;
  logic [CP_W-1:0]    partial_code_r;
  logic [LEFT_W-1:0]  bytes_left_r;
  logic [COUNT_W-1:0] glyph_count_r;
  logic [COUNT_W-1:0] glyph_limit_r;

  logic               out_valid_r;
  logic [CP_W-1:0]    out_cp_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [ATLAS_W-1:0] out_atlas_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_end_r;

  logic               adv;
  logic               res_valid;
  step_t              step;
  class_t             cls;
  logic [COUNT_W-1:0] glyph_count_nxt;

  ugid_utf8_step u_step (
    .text_byte    (a_byte_r),
    .partial_code (partial_code_r),
    .bytes_left   (bytes_left_r),
    .step         (step)
  );

  ugid_classify u_classify (
    .code_point  (step.cp),
    .glyph_count (glyph_count_r),
    .glyph_limit (glyph_limit_r),
    .cls         (cls)
  );

  assign adv         = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || adv;
  assign res_valid   = step.done || a_fin_r;
  assign glyph_count_nxt = (step.done && cls.draw) ? glyph_count_r + 9'd1 : glyph_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      glyph_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      a_valid_r <= 1'b1;
    end else if (adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_byte_r <= in_ch.text_byte;
      a_fin_r  <= in_ch.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_code_r <= '0;
      bytes_left_r   <= '0;
      glyph_count_r  <= '0;
    end else if (adv) begin
      if (a_fin_r) begin
        partial_code_r <= '0;
        bytes_left_r   <= '0;
        glyph_count_r  <= '0;
      end else begin
        partial_code_r <= step.partial_nxt;
        bytes_left_r   <= step.bytes_left_nxt;
        glyph_count_r  <= glyph_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_end_r <= a_fin_r;
      if (step.done) begin
        out_cp_r    <= step.cp;
        out_kind_r  <= cls.kind;
        out_atlas_r <= cls.atlas;
        out_slot_r  <= cls.slot;
      end else begin
        out_cp_r    <= '0;
        out_kind_r  <= KIND_NONE;
        out_atlas_r <= '0;
        out_slot_r  <= '0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_point  = out_cp_r;
  assign out_ch.glyph_kind  = out_kind_r;
  assign out_ch.atlas_index = out_atlas_r;
  assign out_ch.glyph_slot  = out_slot_r;
  assign out_ch.text_end    = out_end_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    glyph_count_r <= SLOT_COUNT)
    else $error("glyph count past slot count");

  a_idle_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r == '0 |-> partial_code_r == '0)
    else $error("partial code held with no sequence open");

  a_draw_counts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step.done && cls.draw && !a_fin_r |=>
      glyph_count_r == $past(glyph_count_r) + 9'd1)
    else $error("drawn glyph did not advance slot count");

  a_word_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    adv && a_fin_r |=> out_valid_r && out_end_r)
    else $error("final byte produced no end word");
endmodule

/* tb/testbench.sv */
// testbench for utf8_glyph_index_decoder: random and directed utf-8 texts against a
// built-in decoder/classifier, random stalls on both channels, glyph limit changes
// depends on ugid_pkg, ugid_if and the decoder rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ugid_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 4;
  localparam int PRINT_LIMIT  = 60;
  localparam int NO_ATLAS     = 255;

  // atlas index by offset from the start of the hiragana or katakana block
  localparam int KANA_ATLAS [96] = '{
    NO_ATLAS, 71, 0, 72, 1, 73, 2, 74, 3, 75, 4, 5, 46, 6, 47, 7,
    48, 8, 49, 9, 50, 10, 51, 11, 52, 12, 53, 13, 54, 14, 55, 15,
    56, 16, 57, 79, 17, 58, 18, 59, 19, 60, 20, 21, 22, 23, 24, 25,
    61, 66, 26, 62, 67, 27, 63, 68, 28, 64, 69, 29, 65, 70, 30, 31,
    32, 33, 34, 76, 35, 77, 36, 78, 37, 38, 39, 40, 41, 42, NO_ATLAS, 43,
    NO_ATLAS, NO_ATLAS, 44, 45, NO_ATLAS, NO_ATLAS, NO_ATLAS, NO_ATLAS,
    NO_ATLAS, NO_ATLAS, NO_ATLAS, NO_ATLAS, NO_ATLAS, NO_ATLAS, NO_ATLAS, NO_ATLAS
  };

  localparam logic [7:0] OPENING_TEXT [25] = '{
    8'h00, 8'h61, 8'h7A, 8'h41, 8'h5A, 8'h30, 8'h39, 8'h0A, 8'h20, 8'hFF,
    8'hE3, 8'h80, 8'h80, 8'hE3, 8'h81, 8'h81, 8'hE3, 8'h83, 8'hBC,
    8'hEF, 8'hBD, 8'hA5, 8'hC1, 8'h81, 8'hF7
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } text_item_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [KIND_W-1:0]  glyph_kind;
    logic [ATLAS_W-1:0] atlas_index;
    logic [SLOT_W-1:0]  glyph_slot;
    logic               text_end;
  } glyph_word_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [COUNT_W-1:0]  cfg_wdata;

  ugid_in_if  in_bus ();
  ugid_out_if out_bus ();

  utf8_glyph_index_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  text_item_t  text_byte_queue [$];
  glyph_word_t pending_glyph_words [$];
  text_item_t  next_item;

  // decoder state as the block should hold it
  logic [CP_W-1:0]    utf8_partial = '0;
  logic [LEFT_W-1:0]  utf8_left    = '0;
  logic [COUNT_W-1:0] glyph_total  = '0;
  logic [COUNT_W-1:0] glyph_cap    = 9'd256;

  logic in_taken;
  logic steady;
  logic sender_hold;
  int   hold_requests;
  int   holds_done;
  int   hold_left;
  int   cycle_count;
  int   error_count;
  int   words_checked;
  int   bytes_queued;
  int   text_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic glyph_word_t classify_code_point(input logic [CP_W-1:0] cp);
    glyph_word_t        w;
    logic [COUNT_W-1:0] cap;
    int                 entry;
    logic [KIND_W-1:0]  k;
    w = '0;
    w.code_point = cp;
    w.glyph_kind = KIND_SKIPPED;
    cap = (glyph_cap > 9'd256) ? 9'd256 : glyph_cap;
    if (glyph_total >= cap) begin
      w.glyph_kind = KIND_BEYOND;
    end else if (cp == 21'h0A) begin
      w.glyph_kind = KIND_NEWLINE;
    end else if (cp == 21'h20) begin
      w.glyph_kind = KIND_HALF_SPACE;
    end else if (cp == 21'h3000) begin
      w.glyph_kind = KIND_FULL_SPACE;
    end else begin
      entry = NO_ATLAS;
      k = KIND_SKIPPED;
      if (cp >= 21'h3040 && cp <= 21'h309F) begin
        entry = KANA_ATLAS[int'(cp - 21'h3040)];
        k = KIND_HIRAGANA;
      end else if (cp >= 21'h30A0 && cp <= 21'h30FF) begin
        entry = (cp == 21'h30FC) ? 80 : KANA_ATLAS[int'(cp - 21'h30A0)];
        k = KIND_KATAKANA;
      end else if (cp >= 21'h61 && cp <= 21'h7A) begin
        entry = int'(cp - 21'h61);
        k = KIND_ALNUM;
      end else if (cp >= 21'h41 && cp <= 21'h5A) begin
        entry = int'(cp - 21'h41) + 26;
        k = KIND_ALNUM;
      end else if (cp >= 21'h30 && cp <= 21'h39) begin
        entry = int'(cp - 21'h30) + 52;
        k = KIND_ALNUM;
      end
      if (k != KIND_SKIPPED && entry != NO_ATLAS) begin
        w.glyph_kind = k;
        w.atlas_index = 7'(entry);
        w.glyph_slot = glyph_total[7:0];
        glyph_total = glyph_total + 9'd1;
      end
    end
    return w;
  endfunction

  function automatic void decode_text_byte(input logic [7:0] b, input logic fin);
    glyph_word_t     w;
    logic            done;
    logic [CP_W-1:0] cp;
    done = 1'b0;
    cp = '0;
    w = '0;
    if (utf8_left == 0) begin
      if (b[7] == 1'b0) begin
        cp = 21'(b);
        done = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        utf8_partial = 21'(b[4:0]) << 6;
        utf8_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        utf8_partial = 21'(b[3:0]) << 12;
        utf8_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        utf8_partial = 21'(b[2:0]) << 18;
        utf8_left = 2'd3;
      end
    end else begin
      utf8_left = utf8_left - 2'd1;
      utf8_partial = utf8_partial | (21'(b[5:0]) << (6 * utf8_left));
      if (utf8_left == 0) begin
        cp = utf8_partial;
        done = 1'b1;
        utf8_partial = '0;
      end
    end
    if (done) begin
      w = classify_code_point(cp);
    end else if (fin) begin
      w.glyph_kind = KIND_NONE;
    end
    if (done || fin) begin
      w.text_end = fin;
      pending_glyph_words = {pending_glyph_words, w};
    end
    if (fin) begin
      utf8_partial = '0;
      utf8_left = '0;
      glyph_total = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
  endtask

  // stimulus helpers
  function automatic void queue_byte(input logic [7:0] b, input logic fin);
    text_item_t item;
    item.text_byte = b;
    item.final_byte = fin;
    text_byte_queue = {text_byte_queue, item};
    bytes_queued++;
  endfunction

  function automatic logic [7:0] lead_byte(input logic [CP_W-1:0] cp, input int n);
    logic [7:0] b;
    case (n)
      2: begin
        b = {3'b110, cp[10:6]};
      end
      3: begin
        b = {4'b1110, cp[15:12]};
      end
      default: begin
        b = {5'b11110, cp[20:18]};
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [CP_W-1:0] bits);
    logic [1:0] top;
    top = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
    return {top, bits[5:0]};
  endfunction

  function automatic logic [CP_W-1:0] pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 21'h61 + 21'(r);
    if (r < 52) return 21'h41 + 21'(r - 26);
    return 21'h30 + 21'(r - 52);
  endfunction

  function automatic logic [CP_W-1:0] pick_code_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 21'h3040 + 21'($urandom_range(0, 95));
    if (r < 45) return 21'h30A0 + 21'($urandom_range(0, 95));
    if (r < 70) return pick_alnum();
    if (r < 75) return 21'h0A;
    if (r < 80) return 21'h20;
    if (r < 83) return 21'h3000;
    if (r < 87) return 21'hFF65 + 21'($urandom_range(0, 58));
    if (r < 93) return 21'($urandom_range(0, 127));
    return 21'($urandom_range(0, 21'h1FFFFF));
  endfunction

  function automatic void queue_code_point(input logic [CP_W-1:0] cp, input logic fin);
    int n;
    n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    // overlong forms now and then
    if (n < 4 && $urandom_range(0, 9) == 0) n = $urandom_range(n + 1, 4);
    if (n == 1) begin
      queue_byte(cp[7:0], fin);
    end else begin
      queue_byte(lead_byte(cp, n), 1'b0);
      for (int k = n - 2; k >= 0; k--) begin
        queue_byte(tail_byte(cp >> (6 * k)), fin && k == 0);
      end
    end
  endfunction

  function automatic void queue_broken_sequence(input logic fin);
    int              n;
    int              tails;
    logic [CP_W-1:0] cp;
    n = $urandom_range(2, 4);
    tails = $urandom_range(0, n - 2);
    cp = 21'($urandom_range(0, 21'h1FFFFF));
    queue_byte(lead_byte(cp, n), fin && tails == 0);
    for (int k = 1; k <= tails; k++) begin
      queue_byte(tail_byte(cp >> (6 * k)), fin && k == tails);
    end
  endfunction

  function automatic void queue_text(input int max_chars);
    int   n_chars;
    int   r;
    logic last;
    n_chars = $urandom_range(1, max_chars);
    for (int i = 0; i < n_chars; i++) begin
      last = (i == n_chars - 1);
      r = $urandom_range(0, 99);
      if (last && r < 12) begin
        queue_broken_sequence(1'b1);
      end else if (last && r < 20) begin
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 5) begin
        queue_byte(8'($urandom_range(0, 255)), last);
      end else if (r < 9) begin
        queue_broken_sequence(last);
      end else begin
        queue_code_point(pick_code_point(), last);
      end
    end
    text_count++;
  endfunction

  function automatic void queue_random_texts(input int n_bytes, input int max_chars);
    int target;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) queue_text(max_chars);
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (text_byte_queue.size() != 0 || in_bus.valid);
    do @(negedge clk); while (pending_glyph_words.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_glyph_limit(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    glyph_cap = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (text_byte_queue.size() != 0 && !sender_hold
          && (steady || $urandom_range(0, 99) >= 7)) begin
        next_item = text_byte_queue.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.text_byte <= next_item.text_byte;
        in_bus.final_byte <= next_item.final_byte;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      out_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_bus.ready <= steady || ($urandom_range(0, 99) >= 7);
    end
  end

  // monitor: check result words first, then predict from the byte taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (out_bus.valid && out_bus.ready) begin
        if (pending_glyph_words.size() == 0) begin
          report_mismatch("word with none expected, code_point", out_bus.code_point, 0);
        end else begin
          automatic glyph_word_t want = pending_glyph_words.pop_front();
          words_checked++;
          if (out_bus.code_point !== want.code_point)
            report_mismatch("code_point", out_bus.code_point, want.code_point);
          if (out_bus.glyph_kind !== want.glyph_kind)
            report_mismatch("glyph_kind", out_bus.glyph_kind, want.glyph_kind);
          if (out_bus.atlas_index !== want.atlas_index)
            report_mismatch("atlas_index", out_bus.atlas_index, want.atlas_index);
          if (out_bus.glyph_slot !== want.glyph_slot)
            report_mismatch("glyph_slot", out_bus.glyph_slot, want.glyph_slot);
          if (out_bus.text_end !== want.text_end)
            report_mismatch("text_end", out_bus.text_end, want.text_end);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        decode_text_byte(in_bus.text_byte, in_bus.final_byte);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.text_byte = '0;
    in_bus.final_byte = 1'b0;
    out_bus.ready = 1'b0;
    in_taken = 1'b0;
    steady = 1'b0;
    sender_hold = 1'b0;
    hold_requests = 0;
    holds_done = 0;
    hold_left = 0;
    cycle_count = 0;
    error_count = 0;
    words_checked = 0;
    bytes_queued = 0;
    text_count = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every kind but beyond, overlong form, text cut off by its final byte
    set_glyph_limit(9'd256);
    foreach (OPENING_TEXT[i]) queue_byte(OPENING_TEXT[i], i == 24);
    text_count++;
    wait_drained();

    set_glyph_limit(9'd0);
    queue_random_texts(150, 8);
    wait_drained();

    set_glyph_limit(9'd1);
    queue_random_texts(150, 8);
    wait_drained();

    // no idling on either side
    set_glyph_limit(9'd5);
    @(negedge clk);
    steady <= 1'b1;
    @(posedge clk);
    queue_random_texts(300, 12);
    wait_drained();
    steady <= 1'b0;

    // limit above the slot count, one text long enough to run out of slots
    set_glyph_limit(9'd511);
    for (int i = 0; i < 300; i++) queue_code_point(pick_alnum(), i == 299);
    text_count++;
    queue_random_texts(100, 20);
    wait_drained();

    // long receiver hold, then a sender pause until all words are back
    set_glyph_limit(9'($urandom_range(2, 40)));
    queue_random_texts(500, 40);
    do @(posedge clk); while (text_byte_queue.size() > 400);
    @(negedge clk);
    hold_requests <= hold_requests + 1;
    do @(posedge clk); while (text_byte_queue.size() > 200);
    @(negedge clk);
    sender_hold <= 1'b1;
    do @(negedge clk); while (pending_glyph_words.size() != 0);
    sender_hold <= 1'b0;
    wait_drained();

    set_glyph_limit(9'd256);
    queue_random_texts(300, 30);
    wait_drained();

    $display("covered %0d bytes in %0d texts, glyph limits 0, 1, 5, 256, 511 and one random",
             bytes_queued, text_count);
    $display("%0d glyph words compared, %0d mismatches", words_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
